// ===== rtl/ctsc_pkg.sv =====
// Shared types, field codes and lookup functions for the clock time set controller.
package ctsc_pkg;

    localparam int NumFields = 6;

    // Codes for the time field under the cursor.
    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_SECOND = 3'd2;
    localparam logic [2:0] FIELD_DAY    = 3'd3;
    localparam logic [2:0] FIELD_MONTH  = 3'd4;
    localparam logic [2:0] FIELD_YEAR   = 3'd5;

    // Command codes of an input word.
    localparam logic CMD_REFRESH = 1'b0;
    localparam logic CMD_BUTTONS = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic       btn_set;
        logic       btn_move;
        logic       btn_up;
        logic [4:0] hour_in;
        logic [5:0] minute_in;
        logic [5:0] second_in;
        logic [4:0] day_in;
        logic [3:0] month_in;
        logic [6:0] year_in;
    } in_word_t;

    typedef struct packed {
        logic       write_valid;
        logic [2:0] write_field;
        logic [6:0] write_value;
        logic [7:0] write_bcd;
        logic       set_mode_on;
        logic [4:0] cursor_column;
        logic       backlight_on;
    } out_word_t;

    // Display column of each field; unused codes fall back to the first column.
    function automatic logic [4:0] column_of(input logic [2:0] idx);
        logic [4:0] col;
        case (idx)
            FIELD_HOUR:   col = 5'd1;
            FIELD_MINUTE: col = 5'd4;
            FIELD_SECOND: col = 5'd7;
            FIELD_DAY:    col = 5'd10;
            FIELD_MONTH:  col = 5'd13;
            FIELD_YEAR:   col = 5'd16;
            default:      col = 5'd1;
        endcase
        return col;
    endfunction

    // Month length; February has 29 days in every year divisible by four,
    // and an invalid month counts as 31 days.
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/clock_time_set_controller.sv =====
// Top level of the clock time set controller: input register, update logic, result register.
//
// Usage: each input word is either a refresh (cmd low) that loads hour, minute,
// second, day, month and year read from the real-time clock, or a button sample
// (cmd high). Buttons act by priority: set toggles set mode and homes the cursor,
// move steps the cursor over the six fields, up increments the selected field in
// set mode (reported as a write with binary and BCD value) or toggles the
// backlight otherwise. Every input word yields exactly one result word.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; a word
// moves on a rising edge with valid high and stall low.
// Path: an accepted word waits in the input register, and its result moves
// through the result register to out_data. Throughput: one word per cycle while
// out_stall stays low, set by the state update between the two registers.
// Reset: set mode off, cursor on the hour, backlight on, time 00:00:00 on day 1,
// month 1, year 0; both registers empty.
// When the receiver stalls, the result holds and the input register still takes
// one more word; after that in_stall rises until the result is taken.
module clock_time_set_controller
    import ctsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic       edit_mode_reg, edit_mode_next;
    logic [2:0] cursor_reg,    cursor_next;
    logic       backlight_reg, backlight_next;
    logic [4:0] hour_reg,      hour_next;
    logic [5:0] minute_reg,    minute_next;
    logic [5:0] second_reg,    second_next;
    logic [4:0] day_reg,       day_next;
    logic [3:0] month_reg,     month_next;
    logic [6:0] year_reg,      year_next;

    logic       advance;
    logic       in_take;
    out_word_t  result;

    logic [7:0]  hour_inc, minute_inc, second_inc, day_inc, month_inc, year_inc;
    logic [6:0]  bump_value;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones;

    // The held word moves to the result register when that register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign hour_inc   = 8'({3'd0, hour_reg}) + 8'd1;
    assign minute_inc = 8'({2'd0, minute_reg}) + 8'd1;
    assign second_inc = 8'({2'd0, second_reg}) + 8'd1;
    assign day_inc    = 8'({3'd0, day_reg}) + 8'd1;
    assign month_inc  = 8'({4'd0, month_reg}) + 8'd1;
    assign year_inc   = 8'({1'd0, year_reg}) + 8'd1;

    // Incremented value of the selected field, wrapped.
    always_comb
    begin
        case (cursor_reg)
            FIELD_HOUR:   bump_value = (hour_inc >= 8'd24) ? 7'd0 : hour_inc[6:0];
            FIELD_MINUTE: bump_value = (minute_inc >= 8'd60) ? 7'd0 : minute_inc[6:0];
            FIELD_SECOND: bump_value = (second_inc >= 8'd60) ? 7'd0 : second_inc[6:0];
            FIELD_DAY:    bump_value = (day_inc > 8'({3'd0, days_in_month(month_reg, year_reg)}))
                                       ? 7'd1 : day_inc[6:0];
            FIELD_MONTH:  bump_value = (month_inc > 8'd12) ? 7'd1 : month_inc[6:0];
            default:      bump_value = (year_inc >= 8'd100) ? 7'd0 : year_inc[6:0];
        endcase
    end

    // Divide by ten through the reciprocal 205/2048, exact for values below 179.
    assign tens_prod = 15'(bump_value) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = bump_value - {3'd0, tens} * 7'd10;

    always_comb
    begin
        edit_mode_next = edit_mode_reg;
        cursor_next    = cursor_reg;
        backlight_next = backlight_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        result.write_valid = 1'b0;
        result.write_field = 3'd0;
        result.write_value = 7'd0;
        result.write_bcd   = 8'd0;

        priority if (in_word_reg.cmd == CMD_REFRESH)
        begin
            hour_next   = in_word_reg.hour_in;
            minute_next = in_word_reg.minute_in;
            second_next = in_word_reg.second_in;
            day_next    = in_word_reg.day_in;
            month_next  = in_word_reg.month_in;
            year_next   = in_word_reg.year_in;
        end
        else if (in_word_reg.btn_set)
        begin
            edit_mode_next = !edit_mode_reg;
            cursor_next    = FIELD_HOUR;
        end
        else if (in_word_reg.btn_move)
        begin
            cursor_next = (cursor_reg >= FIELD_YEAR) ? FIELD_HOUR : cursor_reg + 3'd1;
        end
        else if (in_word_reg.btn_up)
        begin
            if (edit_mode_reg)
            begin
                result.write_valid = 1'b1;
                result.write_field = cursor_reg;
                result.write_value = bump_value;
                result.write_bcd   = {tens, ones[3:0]};
                case (cursor_reg)
                    FIELD_HOUR:   hour_next   = bump_value[4:0];
                    FIELD_MINUTE: minute_next = bump_value[5:0];
                    FIELD_SECOND: second_next = bump_value[5:0];
                    FIELD_DAY:    day_next    = bump_value[4:0];
                    FIELD_MONTH:  month_next  = bump_value[3:0];
                    default:      year_next   = bump_value;
                endcase
            end
            else
            begin
                backlight_next = !backlight_reg;
            end
        end
        else
        begin
            // A sample with no button pressed leaves everything as it is.
        end

        result.set_mode_on   = edit_mode_next;
        result.cursor_column = column_of(cursor_next);
        result.backlight_on  = backlight_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            edit_mode_reg <= 1'b0;
            cursor_reg    <= FIELD_HOUR;
            backlight_reg <= 1'b1;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 7'd0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                edit_mode_reg <= edit_mode_next;
                cursor_reg    <= cursor_next;
                backlight_reg <= backlight_next;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                second_reg    <= second_next;
                day_reg       <= day_next;
                month_reg     <= month_next;
                year_reg      <= year_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= in_data;
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= FIELD_YEAR)
        else $error("cursor left the six fields");

    a_write_in_set_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_valid |-> out_data.set_mode_on)
        else $error("field write outside set mode");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_valid |->
            out_data.write_field == 3'd0 && out_data.write_value == 7'd0
            && out_data.write_bcd == 8'd0)
        else $error("write fields not cleared without a write");

    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_valid |-> out_data.write_bcd[3:0] <= 4'd9)
        else $error("BCD ones digit out of range");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room to spare");
`endif

endmodule
